// ===== src/linear_probe_hash_map_defines.svh =====
// ----------------------------------------------------------------------------
// Linear probe hash map assertion macros
// Shared concurrent assertion wrappers, sampled on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_DEFINES_SVH

`ifndef SYNTH
`define LPHM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lphm assertion failed");
`define LPHM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lphm forbidden condition");
`else
`define LPHM_ASSERT(lbl, prop)
`define LPHM_NEVER(lbl, cond)
`endif

`endif

// ===== src/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map package
// Beat types, slot mark and operation codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] MARK_EMPTY    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_TOMB     = 2'd2;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam int unsigned COUNT_W = 11;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic signed [31:0]   value_out;
    logic [COUNT_W-1:0]   occupied_count;
  } rsp_t;

  typedef struct packed {
    logic       item_load;
    logic       sweep;
    logic       ptr_zero;
    logic       hash_load;
    logic       step;
    logic       tomb_rec;
    logic       wr_mark_en;
    logic [1:0] wr_mark;
    logic       wr_key;
    logic       wr_val;
    logic       wr_at_tomb;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_set;
    logic       res_ok;
    logic       res_found;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mark;
    logic       key_hit;
    logic       cnt_zero;
    logic       probe_last;
    logic       sweep_last;
    logic       have_tomb;
    logic       out_free;
  } status_t;

endpackage

// ===== src/lphm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map controller
// Sequences clear sweeps, hashing, probing, slot updates and result handoff.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_defines.svh"

module lphm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lphm_pkg::status_t st_i,
  output lphm_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       clr_reply_q, clr_reply_d;
  logic       occ, hit, tomb_here, empty;

  assign occ       = (st_i.mark == lphm_pkg::MARK_OCCUPIED);
  assign hit       = occ && st_i.key_hit;
  assign tomb_here = (st_i.mark == lphm_pkg::MARK_TOMB);
  assign empty     = (st_i.mark == lphm_pkg::MARK_EMPTY);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    clr_reply_d = clr_reply_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_last) begin
          clr_reply_d = 1'b0;
          if (clr_reply_q) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_ok  = 1'b1;
            state_d       = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_START;
        end
      end
      S_START: begin
        if (st_i.kind == lphm_pkg::KIND_CLEAR) begin
          cmd_o.ptr_zero = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          clr_reply_d    = 1'b1;
          state_d        = S_CLEAR;
        end else if (st_i.kind != lphm_pkg::KIND_INSERT && st_i.cnt_zero) begin
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.hash_load = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (st_i.kind == lphm_pkg::KIND_INSERT) begin
          if (hit) begin
            cmd_o.wr_val  = 1'b1;
            cmd_o.res_set = 1'b1;
            cmd_o.res_ok  = 1'b1;
            state_d       = S_RESP;
          end else if (empty) begin
            cmd_o.wr_mark_en = 1'b1;
            cmd_o.wr_mark    = lphm_pkg::MARK_OCCUPIED;
            cmd_o.wr_key     = 1'b1;
            cmd_o.wr_val     = 1'b1;
            cmd_o.wr_at_tomb = st_i.have_tomb;
            cmd_o.cnt_inc    = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_ok     = 1'b1;
            state_d          = S_RESP;
          end else begin
            cmd_o.tomb_rec = tomb_here && !st_i.have_tomb;
            if (st_i.probe_last) begin
              cmd_o.res_set = 1'b1;
              state_d       = S_RESP;
              if (st_i.have_tomb || tomb_here) begin
                cmd_o.wr_mark_en = 1'b1;
                cmd_o.wr_mark    = lphm_pkg::MARK_OCCUPIED;
                cmd_o.wr_key     = 1'b1;
                cmd_o.wr_val     = 1'b1;
                cmd_o.wr_at_tomb = st_i.have_tomb;
                cmd_o.cnt_inc    = 1'b1;
                cmd_o.res_ok     = 1'b1;
              end
            end else begin
              cmd_o.step = 1'b1;
              state_d    = S_READ;
            end
          end
        end else begin
          if (hit) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_ok  = 1'b1;
            state_d       = S_RESP;
            if (st_i.kind == lphm_pkg::KIND_DELETE) begin
              cmd_o.wr_mark_en = 1'b1;
              cmd_o.wr_mark    = lphm_pkg::MARK_TOMB;
              cmd_o.cnt_dec    = 1'b1;
            end else begin
              cmd_o.res_found = 1'b1;
            end
          end else if (empty || st_i.probe_last) begin
            cmd_o.res_set = 1'b1;
            state_d       = S_RESP;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = S_READ;
          end
        end
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_reply_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_reply_q <= clr_reply_d;
    end
  end

  `LPHM_ASSERT(a_load_when_free, cmd_o.out_load |-> st_i.out_free)
  `LPHM_ASSERT(a_no_step_past_wrap, cmd_o.step |-> !st_i.probe_last)
  `LPHM_ASSERT(a_eval_after_read, state_q == S_READ |=> state_q == S_EVAL)

endmodule

// ===== src/lphm_datapath.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map datapath
// Slot stores, probe pointer, hash multiplier, occupancy count, result register.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_defines.svh"

module lphm_datapath #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lphm_pkg::req_t    in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lphm_pkg::rsp_t    out_data_o,
  input  lphm_pkg::cmd_t    cmd_i,
  output lphm_pkg::status_t st_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  logic [1:0]  mark_mem [SLOTS];
  logic [31:0] key_mem  [SLOTS];
  logic [31:0] val_mem  [SLOTS];

  logic [1:0]       kind_q;
  logic [31:0]      key_q, value_q;
  logic [IDX_W-1:0] ptr_q, n_q, tomb_q;
  logic             have_tomb_q;
  logic [CNT_W-1:0] count_q;
  logic [1:0]       rd_mark_q;
  logic [31:0]      rd_key_q, rd_val_q;
  logic             res_ok_q;
  logic [31:0]      res_val_q;
  logic             out_valid_q;
  lphm_pkg::rsp_t   out_q;

  logic [31:0]      hash_prod;
  logic [IDX_W-1:0] wr_addr, mark_wa;
  logic             mark_we;
  logic [1:0]       mark_wd;
  logic [31:0]      cnt_ext;

  assign hash_prod = {16'b0, key_q[15:0]} * {16'b0, lphm_pkg::HASH_MULT[15:0]};
  assign wr_addr   = cmd_i.wr_at_tomb ? tomb_q : ptr_q;
  assign mark_we   = cmd_i.sweep || cmd_i.wr_mark_en;
  assign mark_wa   = cmd_i.sweep ? ptr_q : wr_addr;
  assign mark_wd   = cmd_i.sweep ? lphm_pkg::MARK_EMPTY : cmd_i.wr_mark;
  assign cnt_ext   = 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (cmd_i.wr_key) begin
      key_mem[wr_addr] <= key_q;
    end
    if (cmd_i.wr_val) begin
      val_mem[wr_addr] <= value_q;
    end
    rd_mark_q <= mark_mem[ptr_q];
    rd_key_q  <= key_mem[ptr_q];
    rd_val_q  <= val_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      kind_q  <= in_data_i.kind;
      key_q   <= in_data_i.key;
      value_q <= in_data_i.value;
    end
    if (cmd_i.tomb_rec) begin
      tomb_q <= ptr_q;
    end
    if (cmd_i.res_set) begin
      res_ok_q  <= cmd_i.res_ok;
      res_val_q <= cmd_i.res_found ? rd_val_q : 32'd0;
    end
    if (cmd_i.out_load) begin
      out_q.ok             <= res_ok_q;
      out_q.value_out      <= res_val_q;
      out_q.occupied_count <= cnt_ext[lphm_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      n_q         <= '0;
      have_tomb_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ptr_zero) begin
        ptr_q <= '0;
      end else if (cmd_i.hash_load) begin
        ptr_q <= hash_prod[IDX_W-1:0];
      end else if (cmd_i.sweep || cmd_i.step) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.hash_load) begin
        n_q         <= '0;
        have_tomb_q <= 1'b0;
      end else begin
        if (cmd_i.step) begin
          n_q <= n_q + 1'b1;
        end
        if (cmd_i.tomb_rec) begin
          have_tomb_q <= 1'b1;
        end
      end
      if (cmd_i.cnt_clr) begin
        count_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec && count_q != '0) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.kind       = kind_q;
  assign st_o.mark       = rd_mark_q;
  assign st_o.key_hit    = (rd_key_q == key_q);
  assign st_o.cnt_zero   = (count_q == '0);
  assign st_o.probe_last = (n_q == '1);
  assign st_o.sweep_last = (ptr_q == '1);
  assign st_o.have_tomb  = have_tomb_q;
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPHM_NEVER(a_count_in_range, count_q > CNT_W'(SLOTS))
  `LPHM_NEVER(a_no_insert_when_full, cmd_i.cnt_inc && count_q == CNT_W'(SLOTS))
  `LPHM_ASSERT(a_dec_nonzero, cmd_i.cnt_dec |-> count_q != '0)

endmodule

// ===== src/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map
// Open-addressing key/value map with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One operation is handled at a time. The beat is taken in an idle cycle; lookup,
// insert and delete then load the home slot (low bits of key * 2654435761) and
// probe it and the slots after it, each with a registered read of the slot
// stores and then the compare and any write, wrapping over at most SLOTS slots.
// The result is handed to the output register once that register is free. A
// lookup or delete on an empty map answers without probing. Clear all walks the
// mark store one slot per cycle. After reset the same sweep runs before the
// first beat is taken. SLOTS must be a power of two.
module linear_probe_hash_map #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lphm_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lphm_pkg::rsp_t out_data_o
);

  lphm_pkg::cmd_t    cmd;
  lphm_pkg::status_t st;

  lphm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  lphm_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear probe hash map testbench
// Directed and random lookup/insert/delete/clear traffic with a full-table
// phase, checked beat by beat against a behavioral copy of the map.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned POOL_N      = 48;
  localparam int unsigned PHASE_LEN   = 120;
  localparam int unsigned QUIET_LIMIT = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lphm_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lphm_pkg::rsp_t out_data_o;

  linear_probe_hash_map #(.SLOTS(SLOTS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // map shadow
  logic [1:0]  shadow_mark [SLOTS];
  logic [31:0] shadow_key  [SLOTS];
  logic [31:0] shadow_val  [SLOTS];
  int unsigned shadow_count;

  lphm_pkg::req_t op_queue[$];
  lphm_pkg::rsp_t answer_q[$];
  logic [31:0] key_pool [POOL_N];
  logic [31:0] fill_key [SLOTS];
  int unsigned ops_taken  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left  = 0;
  bit          hold_used  = 1'b0;
  int          mismatches = 0;

  function automatic int unsigned home_of(logic [31:0] k);
    logic [63:0] prod;
    prod = {{32{k[31]}}, k} * {32'd0, lphm_pkg::HASH_MULT};
    return int'(prod % SLOTS);
  endfunction

  function automatic void shadow_clear();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_mark[i] = lphm_pkg::MARK_EMPTY;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
    end
    shadow_count = 0;
  endfunction

  function automatic lphm_pkg::rsp_t map_apply(lphm_pkg::req_t r);
    lphm_pkg::rsp_t e;
    int unsigned idx;
    int unsigned tomb;
    int unsigned dst;
    bit          hit;
    bit          got_tomb;
    bit          done;
    bit          do_place;
    e = '0;
    idx = home_of(r.key);
    tomb = 0;
    dst = 0;
    hit = 1'b0;
    got_tomb = 1'b0;
    done = 1'b0;
    do_place = 1'b0;
    case (r.kind)
      lphm_pkg::KIND_LOOKUP, lphm_pkg::KIND_DELETE: begin
        if (shadow_count != 0) begin
          for (int n = 0; n < SLOTS && !done; n++) begin
            if (shadow_mark[idx] == lphm_pkg::MARK_EMPTY) begin
              done = 1'b1;
            end else if (shadow_mark[idx] == lphm_pkg::MARK_OCCUPIED &&
                         shadow_key[idx] == r.key) begin
              hit = 1'b1;
              done = 1'b1;
            end else begin
              idx = (idx + 1) % SLOTS;
            end
          end
        end
        if (hit) begin
          e.ok = 1'b1;
          if (r.kind == lphm_pkg::KIND_LOOKUP) begin
            e.value_out = shadow_val[idx];
          end else begin
            shadow_mark[idx] = lphm_pkg::MARK_TOMB;
            shadow_key[idx]  = '0;
            shadow_val[idx]  = '0;
            if (shadow_count > 0) shadow_count--;
          end
        end
      end
      lphm_pkg::KIND_INSERT: begin
        for (int n = 0; n < SLOTS && !done; n++) begin
          if (shadow_mark[idx] == lphm_pkg::MARK_OCCUPIED && shadow_key[idx] == r.key) begin
            shadow_val[idx] = r.value;
            e.ok = 1'b1;
            done = 1'b1;
          end else begin
            if (shadow_mark[idx] == lphm_pkg::MARK_TOMB && !got_tomb) begin
              got_tomb = 1'b1;
              tomb = idx;
            end
            if (shadow_mark[idx] == lphm_pkg::MARK_EMPTY) begin
              do_place = 1'b1;
              dst = got_tomb ? tomb : idx;
              done = 1'b1;
            end else begin
              idx = (idx + 1) % SLOTS;
            end
          end
        end
        // full wrap: fall back to the first tombstone
        if (!done && got_tomb) begin
          do_place = 1'b1;
          dst = tomb;
        end
        if (do_place) begin
          shadow_key[dst]  = r.key;
          shadow_val[dst]  = r.value;
          shadow_mark[dst] = lphm_pkg::MARK_OCCUPIED;
          shadow_count++;
          e.ok = 1'b1;
        end
      end
      default: begin
        shadow_clear();
        e.ok = 1'b1;
      end
    endcase
    e.occupied_count = shadow_count[lphm_pkg::COUNT_W-1:0];
    return e;
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned phase_of(int unsigned n);
    return (n / PHASE_LEN) % 4;
  endfunction

  function automatic int unsigned send_gap_pct(int unsigned ph);
    return (ph == 1) ? 65 : (ph == 3) ? 9 : 0;
  endfunction

  function automatic int unsigned sink_stall_pct(int unsigned ph);
    return (ph == 2) ? 65 : (ph == 3) ? 9 : 0;
  endfunction

  task automatic add_op(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
    lphm_pkg::req_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    op_queue.push_back(r);
  endtask

  task automatic add_mixed(int count);
    int unsigned sel;
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      k = chance(85) ? key_pool[$urandom_range(0, POOL_N - 1)] : $urandom;
      if (sel < 2)       add_op(lphm_pkg::KIND_CLEAR, $urandom, $urandom);
      else if (sel < 42) add_op(lphm_pkg::KIND_INSERT, k, $urandom);
      else if (sel < 72) add_op(lphm_pkg::KIND_LOOKUP, k, $urandom);
      else               add_op(lphm_pkg::KIND_DELETE, k, $urandom);
    end
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        answer_q.push_back(map_apply(in_data_i));
        ops_taken <= ops_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (op_queue.size() != 0 && !chance(send_gap_pct(phase_of(ops_taken)))) begin
          in_valid_i <= 1'b1;
          in_data_i  <= op_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    lphm_pkg::rsp_t got;
    lphm_pkg::rsp_t want;
    bit   start_hold;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (answer_q.size() == 0) begin
          flag_mismatch("unexpected result beat", got.value_out, '0);
        end else begin
          want = answer_q.pop_front();
          if (got.ok !== want.ok)
            flag_mismatch("ok", 32'(got.ok), 32'(want.ok));
          if (got.value_out !== want.value_out)
            flag_mismatch("value_out", got.value_out, want.value_out);
          if (got.occupied_count !== want.occupied_count)
            flag_mismatch("occupied_count", 32'(got.occupied_count),
                          32'(want.occupied_count));
        end
      end
      // one long back-pressure stretch early in the run
      start_hold = !hold_used && ops_taken >= 60;
      if (start_hold) begin
        hold_used <= 1'b1;
        hold_left <= 250;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_ready_i <= !start_hold && hold_left == 0 &&
                     !chance(sink_stall_pct(phase_of(ops_taken)));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] rnd;
    shadow_clear();
    for (int i = 0; i < POOL_N; i++) begin
      rnd = $urandom;
      key_pool[i] = {rnd[31:10], 10'($urandom_range(0, 11))};
    end

    // directed
    add_op(lphm_pkg::KIND_LOOKUP, 32'd5, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'd5, 32'd0);
    add_op(lphm_pkg::KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    add_op(lphm_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    add_op(lphm_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    add_op(lphm_pkg::KIND_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    add_op(lphm_pkg::KIND_INSERT, 32'h0000_0400, 32'h5a5a_5a5a);
    add_op(lphm_pkg::KIND_INSERT, 32'h0000_0800, 32'ha5a5_a5a5);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h8000_0000, 32'd0);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h7fff_ffff, 32'd0);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0800, 32'd0);
    add_op(lphm_pkg::KIND_INSERT, 32'h0000_0000, 32'd123);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h0000_0400, 32'd0);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0800, 32'd0);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0400, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h0000_0400, 32'd0);
    add_op(lphm_pkg::KIND_INSERT, 32'h0000_0c00, 32'h1234_5678);
    add_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0c00, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h0000_0000, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h0000_0800, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h0000_0c00, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h8000_0000, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'h7fff_ffff, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, 32'hffff_ffff, 32'd0);
    // empty map, tombstones left behind
    add_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0800, 32'd0);
    add_op(lphm_pkg::KIND_INSERT, 32'd7, 32'd9);
    add_op(lphm_pkg::KIND_CLEAR, 32'd0, 32'd0);
    add_op(lphm_pkg::KIND_CLEAR, 32'd0, 32'd0);

    add_mixed(40);

    // fill every slot: low key bits pick distinct home slots
    add_op(lphm_pkg::KIND_CLEAR, 32'd0, 32'd0);
    for (int j = 0; j < SLOTS; j++) begin
      rnd = $urandom;
      fill_key[j] = {rnd[31:10], 10'(j)};
      add_op(lphm_pkg::KIND_INSERT, fill_key[j], $urandom);
    end
    add_op(lphm_pkg::KIND_INSERT, fill_key[5] ^ 32'h8000_0000, $urandom);
    add_op(lphm_pkg::KIND_LOOKUP, fill_key[5] ^ 32'h8000_0000, 32'd0);
    add_op(lphm_pkg::KIND_DELETE, fill_key[5] ^ 32'h8000_0000, 32'd0);
    add_op(lphm_pkg::KIND_LOOKUP, fill_key[1023], 32'd0);
    add_op(lphm_pkg::KIND_INSERT, fill_key[7], $urandom);
    add_op(lphm_pkg::KIND_DELETE, fill_key[300], 32'd0);
    add_op(lphm_pkg::KIND_DELETE, fill_key[301], 32'd0);
    add_op(lphm_pkg::KIND_LOOKUP, fill_key[300], 32'd0);
    add_op(lphm_pkg::KIND_INSERT, fill_key[5] ^ 32'h8000_0000, $urandom);
    add_op(lphm_pkg::KIND_INSERT, fill_key[302] ^ 32'h0040_0000, $urandom);
    add_op(lphm_pkg::KIND_INSERT, fill_key[9] ^ 32'h0040_0000, $urandom);
    add_op(lphm_pkg::KIND_LOOKUP, fill_key[5] ^ 32'h8000_0000, 32'd0);
    add_op(lphm_pkg::KIND_CLEAR, 32'd0, 32'd0);

    add_mixed(30);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() != 0 || in_valid_i || answer_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
